// File: rtl/sem_pkg.sv
// Shared constants and types for the multi-turn encoder SPI read sequencer.
// Used by sem_unwrap and spi_encoder_read_multiturn_unit; no dependencies.
package sem_pkg;

    localparam int ROTATION_BITS_DEF = 16;
    localparam int POSITION_BITS     = 12;
    localparam int TURN_W            = 29;
    localparam int RES_W             = 13;
    localparam int THRESH_W          = 12;
    localparam int POLL_W            = 8;
    localparam int ATTEMPT_W         = 4;
    localparam int BYTE_W            = 8;
    localparam int NIBBLE_W          = 4;
    localparam int CFG_IDX_W         = 2;

    localparam logic [BYTE_W-1:0] CMD_READ = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_NOP  = 8'h00;

    localparam logic [RES_W-1:0]     RES_RST     = 13'd4096;
    localparam logic [THRESH_W-1:0]  THRESH_RST  = 12'd3000;
    localparam logic [POLL_W-1:0]    POLL_RST    = 8'd10;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_RST = 4'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESOLUTION    = 2'd0,
        CFG_WRAP_THRESH   = 2'd1,
        CFG_POLL_LIMIT    = 2'd2,
        CFG_ATTEMPT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [TURN_W-1:0]        t_turn;

endpackage

// File: rtl/sem_unwrap.sv
// Turn unwrap: rotation update from the position jump and multi-turn count.
// Depends on sem_pkg.
module sem_unwrap #(
    parameter int ROTATION_BITS = sem_pkg::ROTATION_BITS_DEF
) (
    input  sem_pkg::t_pos                   i_prev,
    input  sem_pkg::t_pos                   i_cur,
    input  logic [ROTATION_BITS-1:0]        i_rot,
    input  logic [sem_pkg::THRESH_W-1:0]    i_thresh,
    input  logic [sem_pkg::RES_W-1:0]       i_res,
    output logic [ROTATION_BITS-1:0]        o_rot,
    output sem_pkg::t_turn                  o_turn
);
    import sem_pkg::*;

    localparam int WIDE_W = (ROTATION_BITS > TURN_W) ? ROTATION_BITS : TURN_W;

    t_pos                     jump;
    logic                     wrap;
    logic signed [WIDE_W-1:0] rot_wide;
    t_turn                    rot_ext;
    t_turn                    prod;

    always_comb begin
        jump = (i_prev > i_cur) ? (i_prev - i_cur) : (i_cur - i_prev);
        wrap = (THRESH_W'(jump) >= i_thresh);
        o_rot = i_rot;
        if (wrap && (i_prev > i_cur)) begin
            o_rot = i_rot + ROTATION_BITS'(1);
        end else if (wrap && (i_prev < i_cur)) begin
            o_rot = i_rot - ROTATION_BITS'(1);
        end
        rot_wide = WIDE_W'(signed'(o_rot));
        rot_ext  = rot_wide[TURN_W-1:0];
        prod     = rot_ext * TURN_W'(i_res);
        o_turn   = prod + TURN_W'(i_cur);
    end

endmodule

// File: rtl/spi_encoder_read_multiturn_unit.sv
// Top level of the multi-turn absolute encoder SPI read sequencer.
// Depends on sem_pkg and sem_unwrap.
//
//  channel | direction | handshake               | payload
//  in      | to block  | i_in_valid / o_in_stall | i_mode, i_rx_byte
//  out     | from block| o_out_valid / i_out_stall| tx_byte .. count_valid
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One beat per cycle sustained while the output is not stalled; each beat is
// held in the input register and is then processed into the result register.
// A stalled result holds; the input register still takes one more beat.
// Synchronous active-low reset returns to idle with control registers at defaults.
module spi_encoder_read_multiturn_unit #(
    parameter int ROTATION_BITS = sem_pkg::ROTATION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_mode,
    input  logic [sem_pkg::BYTE_W-1:0]      i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [sem_pkg::BYTE_W-1:0]      o_tx_byte,
    output logic                            o_send_next,
    output logic                            o_done_res,
    output logic                            o_failed,
    output sem_pkg::t_pos                   o_position,
    output logic signed [sem_pkg::TURN_W-1:0] o_turn_count,
    output logic                            o_count_valid,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sem_pkg::RES_W-1:0]       i_cfg_data
);
    import sem_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CMD   = 3'd1,
        PH_POLL  = 3'd2,
        PH_MSB   = 3'd3,
        PH_LSB   = 3'd4,
        PH_DUMMY = 3'd5
    } t_phase;

    logic [RES_W-1:0]         r_res;
    logic [THRESH_W-1:0]      r_thresh;
    logic [POLL_W-1:0]        r_poll_lim;
    logic [ATTEMPT_W-1:0]     r_att_lim;

    logic                     r_i_vld;
    logic                     r_i_mode;
    logic [BYTE_W-1:0]        r_i_rx;

    t_phase                   r_phase,    n_phase;
    logic [POLL_W-1:0]        r_poll,     n_poll;
    logic [ATTEMPT_W-1:0]     r_att,      n_att;
    logic [NIBBLE_W-1:0]      r_msb,      n_msb;
    t_pos                     r_prev,     n_prev;
    t_pos                     r_cur,      n_cur;
    logic [ROTATION_BITS-1:0] r_rot,      n_rot;
    logic                     r_init,     n_init;

    logic                     r_o_vld;
    logic [BYTE_W-1:0]        r_tx,       n_tx;
    logic                     r_send,     n_send;
    logic                     r_done,     n_done;
    logic                     r_fail,     n_fail;
    t_pos                     r_pos,      n_pos;
    t_turn                    r_turn,     n_turn;
    logic                     r_cvalid,   n_cvalid;

    logic                     o_adv, proc, in_acc;
    logic [ATTEMPT_W-1:0]     att_inc;
    logic [ROTATION_BITS-1:0] uw_rot;
    t_turn                    uw_turn;

    assign o_adv       = !r_o_vld || !i_out_stall;
    assign proc        = r_i_vld && o_adv;
    assign o_in_stall  = r_i_vld && !o_adv;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    sem_unwrap #(
        .ROTATION_BITS (ROTATION_BITS)
    ) u_unwrap (
        .i_prev   (r_prev),
        .i_cur    (r_cur),
        .i_rot    (r_rot),
        .i_thresh (r_thresh),
        .i_res    (r_res),
        .o_rot    (uw_rot),
        .o_turn   (uw_turn)
    );

    assign att_inc = r_att + ATTEMPT_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_poll   = r_poll;
        n_att    = r_att;
        n_msb    = r_msb;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_rot    = r_rot;
        n_init   = r_init;
        n_tx     = CMD_NOP;
        n_send   = 1'b0;
        n_done   = 1'b0;
        n_fail   = 1'b0;
        n_pos    = '0;
        n_turn   = '0;
        n_cvalid = 1'b0;
        if (!r_i_mode) begin
            n_phase = PH_CMD;
            n_poll  = '0;
            n_att   = '0;
            n_tx    = CMD_READ;
            n_send  = 1'b1;
        end else begin
            unique case (r_phase)
                PH_CMD: begin
                    n_phase = PH_POLL;
                    n_poll  = '0;
                    n_send  = 1'b1;
                end
                PH_POLL: begin
                    if (r_poll >= r_poll_lim) begin
                        n_att = att_inc;
                        if (att_inc >= r_att_lim) begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                            n_fail  = 1'b1;
                        end else if (r_i_rx == CMD_READ) begin
                            n_phase = PH_MSB;
                            n_send  = 1'b1;
                        end else begin
                            n_phase = PH_CMD;
                            n_poll  = '0;
                            n_tx    = CMD_READ;
                            n_send  = 1'b1;
                        end
                    end else if (r_i_rx == CMD_READ) begin
                        n_phase = PH_MSB;
                        n_send  = 1'b1;
                    end else begin
                        n_poll = r_poll + POLL_W'(1);
                        n_send = 1'b1;
                    end
                end
                PH_MSB: begin
                    n_msb   = r_i_rx[NIBBLE_W-1:0];
                    n_phase = PH_LSB;
                    n_send  = 1'b1;
                end
                PH_LSB: begin
                    n_cur   = POSITION_BITS'({r_msb, r_i_rx});
                    n_phase = PH_DUMMY;
                    n_send  = 1'b1;
                end
                PH_DUMMY: begin
                    n_phase = PH_IDLE;
                    n_done  = 1'b1;
                    n_pos   = r_cur;
                    n_prev  = r_cur;
                    if (!r_init) begin
                        n_init = 1'b1;
                    end else begin
                        n_rot    = uw_rot;
                        n_turn   = uw_turn;
                        n_cvalid = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res      <= RES_RST;
            r_thresh   <= THRESH_RST;
            r_poll_lim <= POLL_RST;
            r_att_lim  <= ATTEMPT_RST;
            r_i_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
            r_phase    <= PH_IDLE;
            r_poll     <= '0;
            r_att      <= '0;
            r_msb      <= '0;
            r_prev     <= '0;
            r_cur      <= '0;
            r_rot      <= '0;
            r_init     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_RESOLUTION:    r_res      <= i_cfg_data;
                    CFG_WRAP_THRESH:   r_thresh   <= i_cfg_data[THRESH_W-1:0];
                    CFG_POLL_LIMIT:    r_poll_lim <= i_cfg_data[POLL_W-1:0];
                    CFG_ATTEMPT_LIMIT: r_att_lim  <= i_cfg_data[ATTEMPT_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_i_vld  <= 1'b1;
                r_i_mode <= i_mode;
                r_i_rx   <= i_rx_byte;
            end else if (proc) begin
                r_i_vld <= 1'b0;
            end
            if (o_adv) begin
                r_o_vld <= proc;
            end
            if (proc) begin
                r_phase  <= n_phase;
                r_poll   <= n_poll;
                r_att    <= n_att;
                r_msb    <= n_msb;
                r_prev   <= n_prev;
                r_cur    <= n_cur;
                r_rot    <= n_rot;
                r_init   <= n_init;
                r_tx     <= n_tx;
                r_send   <= n_send;
                r_done   <= n_done;
                r_fail   <= n_fail;
                r_pos    <= n_pos;
                r_turn   <= n_turn;
                r_cvalid <= n_cvalid;
            end
        end
    end

    assign o_out_valid   = r_o_vld;
    assign o_tx_byte     = r_tx;
    assign o_send_next   = r_send;
    assign o_done_res    = r_done;
    assign o_failed      = r_fail;
    assign o_position    = r_pos;
    assign o_turn_count  = signed'(r_turn);
    assign o_count_valid = r_cvalid;

endmodule
